@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the port checker of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, suspended while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, suspended while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/xrng_pkg.sv @@
// ---------------------------------------------------------------------------
// xrng_pkg
// Types, constants and helper functions of the xoshiro256** generator.
// ---------------------------------------------------------------------------
package xrng_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] SEED_SALT  = 64'h0000_0010_7060_1686;
    // byte-swapped salt
    localparam logic [WORD_W-1:0] SALT_BSWAP = 64'h8616_6070_1000_0000;

    localparam int unsigned ROT_OUT   = 7;
    localparam int unsigned ROT_STATE = 45;
    localparam int unsigned SHL_STATE = 17;

    typedef enum logic [1:0] {
        OP_RESEED = 2'd0,
        OP_RAW    = 2'd1,
        OP_RANGED = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic {
        CFG_SEED_UPPER = 1'b0,
        CFG_SEED_LOWER = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCRAMBLE,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_seed;
        logic start_draw;
        logic scramble;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ranged_nz;
        logic div_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input int unsigned k);
        rotl64 = (x << k) | (x >> (WORD_W - k));
    endfunction

    function automatic logic [WORD_W-1:0] bswap64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W / 8; i++) begin
            r[8*i +: 8] = x[WORD_W-8-8*i +: 8];
        end
        bswap64 = r;
    endfunction

endpackage

@@ hdl/xrng_ctrl.sv @@
// ---------------------------------------------------------------------------
// xrng_ctrl
// Sequencer: accepts an item, steps the datapath through scramble and
// modulo reduction, and hands the result to the output register.
// ---------------------------------------------------------------------------
module xrng_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  xrng_pkg::t_op         i_op,
    input  xrng_pkg::t_dp_status  i_status,
    output logic                  o_ready,
    output xrng_pkg::t_dp_cmd     o_cmd
);

    xrng_pkg::t_state r_state;
    xrng_pkg::t_state n_state;
    logic             is_draw;

    assign is_draw = (i_op == xrng_pkg::OP_RAW) || (i_op == xrng_pkg::OP_RANGED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xrng_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xrng_pkg::ST_IDLE: begin
                if (i_valid && is_draw) begin
                    n_state = xrng_pkg::ST_SCRAMBLE;
                end
            end
            xrng_pkg::ST_SCRAMBLE: begin
                n_state = i_status.ranged_nz ? xrng_pkg::ST_DIVIDE : xrng_pkg::ST_DONE;
            end
            xrng_pkg::ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = xrng_pkg::ST_DONE;
                end
            end
            xrng_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = xrng_pkg::ST_IDLE;
                end
            end
            default: n_state = xrng_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            xrng_pkg::ST_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.load_seed  = i_valid && (i_op == xrng_pkg::OP_RESEED);
                o_cmd.start_draw = i_valid && is_draw;
            end
            xrng_pkg::ST_SCRAMBLE: begin
                o_cmd.scramble = 1'b1;
            end
            xrng_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            xrng_pkg::ST_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hdl/xrng_dp.sv @@
// ---------------------------------------------------------------------------
// xrng_dp
// Datapath: seed registers, generator state, output scrambler, restoring
// modulo unit (one bit per cycle) and the output register.
// ---------------------------------------------------------------------------
module xrng_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  xrng_pkg::t_dp_cmd            i_cmd,
    output xrng_pkg::t_dp_status         o_status,
    input  xrng_pkg::t_op                i_op,
    input  logic [xrng_pkg::WORD_W-1:0]  i_modulus,
    input  logic                         i_cfg_valid,
    input  xrng_pkg::t_cfg_idx           i_cfg_index,
    input  logic [xrng_pkg::WORD_W-1:0]  i_cfg_data,
    input  logic                         i_m_ready,
    output logic                         o_m_valid,
    output logic [xrng_pkg::WORD_W-1:0]  o_m_data,
    output logic                         o_m_bad
);

    localparam int unsigned W = xrng_pkg::WORD_W;
    localparam logic [xrng_pkg::CNT_W-1:0] DIV_LAST = xrng_pkg::CNT_W'(W - 1);

    logic [W-1:0] r_seed_upper, r_seed_lower;
    logic [W-1:0] r_s0, r_s1, r_s2, r_s3;
    logic [W-1:0] r_p5;
    logic [W-1:0] r_val;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_mod;
    logic         r_ranged;
    logic [xrng_pkg::CNT_W-1:0] r_cnt;
    logic         r_out_valid;
    logic [W-1:0] r_out_data;
    logic         r_out_bad;

    logic [W-1:0] seed_h, seed_b;
    logic [W-1:0] n_s0, n_s1, n_s2, n_s3;
    logic [W-1:0] upd_t, upd_2, upd_3;
    logic [W-1:0] p5, r7, scr;
    logic [W:0]   trial, diff;
    logic         ranged_nz;

    assign seed_b = r_seed_lower;
    assign seed_h = r_seed_upper + xrng_pkg::SEED_SALT;

    // xoshiro256 state update
    assign upd_t = r_s1 << xrng_pkg::SHL_STATE;
    assign upd_2 = r_s2 ^ r_s0;
    assign upd_3 = r_s3 ^ r_s1;
    assign n_s1  = r_s1 ^ upd_2;
    assign n_s0  = r_s0 ^ upd_3;
    assign n_s2  = upd_2 ^ upd_t;
    assign n_s3  = xrng_pkg::rotl64(upd_3, xrng_pkg::ROT_STATE);

    // s1 * 5 and (rotl(p, 7)) * 9 as shift-and-add
    assign p5  = r_s1 + (r_s1 << 2);
    assign r7  = xrng_pkg::rotl64(r_p5, xrng_pkg::ROT_OUT);
    assign scr = r7 + (r7 << 3);

    assign trial = {r_rem, r_val[W-1]};
    assign diff  = trial - {1'b0, r_mod};

    assign ranged_nz = r_ranged && (r_mod != '0);

    assign o_status.ranged_nz = ranged_nz;
    assign o_status.div_last  = (r_cnt == DIV_LAST);
    assign o_status.out_free  = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_upper <= '0;
            r_seed_lower <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                xrng_pkg::CFG_SEED_UPPER: r_seed_upper <= i_cfg_data;
                xrng_pkg::CFG_SEED_LOWER: r_seed_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= xrng_pkg::SEED_SALT;
            r_s1 <= xrng_pkg::SALT_BSWAP;
            r_s2 <= xrng_pkg::SEED_SALT;
            r_s3 <= xrng_pkg::SEED_SALT;
        end else if (i_cmd.load_seed) begin
            r_s0 <= seed_h;
            r_s1 <= xrng_pkg::bswap64(seed_h) ^ seed_b;
            r_s2 <= xrng_pkg::bswap64(seed_b) ^ seed_h;
            r_s3 <= seed_b + xrng_pkg::SEED_SALT;
        end else if (i_cmd.start_draw) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_draw) begin
            r_p5     <= p5;
            r_mod    <= i_modulus;
            r_ranged <= (i_op == xrng_pkg::OP_RANGED);
        end
        if (i_cmd.scramble) begin
            r_val <= scr;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            // restoring step: bring in the next dividend bit, subtract if it fits
            r_rem <= diff[W] ? trial[W-1:0] : diff[W-1:0];
            r_val <= r_val << 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= ranged_nz ? r_rem : r_val;
            r_out_bad  <= r_ranged && (r_mod == '0);
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_bad   = r_out_bad;

endmodule

@@ hdl/xoshiro256_starstar_rng_core.sv @@
// Sequence: reseed and unused ops are done in the cycle they are accepted; a raw draw or a
// zero-modulus ranged draw passes from acceptance through the scramble and done states,
// a ranged draw with a nonzero modulus also through the divide state (one bit per cycle).
// Flow: one item at a time; the next item is accepted when the result has moved into
// the output register, which waits while that register still holds a stalled beat.
// Reset (synchronous, active low): seeds are zero, the state is as if reseeded with zero seeds.
// ---------------------------------------------------------------------------
// xoshiro256_starstar_rng_core
// xoshiro256** generator with salted reseed and optional modulo reduction.
// ---------------------------------------------------------------------------
module xoshiro256_starstar_rng_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] modulus
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] random_value
    output logic        o_m_axis_tuser,   // [0] bad_modulus
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    xrng_pkg::t_dp_cmd    cmd;
    xrng_pkg::t_dp_status status;
    xrng_pkg::t_op        op;

    assign op          = xrng_pkg::t_op'(i_s_axis_tuser);
    assign o_cfg_ready = 1'b1;

    xrng_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_op     (op),
        .i_status (status),
        .o_ready  (o_s_axis_tready),
        .o_cmd    (cmd)
    );

    xrng_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (op),
        .i_modulus   (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (xrng_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_data    (o_m_axis_tdata),
        .o_m_bad     (o_m_axis_tuser)
    );

endmodule

@@ hdl/xrng_checker.sv @@
// ---------------------------------------------------------------------------
// xrng_port_checks
// Port-level checks of the generator core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xrng_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_cfg_index,
    input logic [63:0] i_cfg_data
);

    logic        in_beat;
    logic        draw_beat;
    logic        quiet_beat;
    logic        out_stall;
    logic [64:0] out_word;

    assign in_beat    = i_s_axis_tvalid && o_s_axis_tready;
    assign draw_beat  = in_beat && (i_s_axis_tuser == xrng_pkg::OP_RAW ||
                                    i_s_axis_tuser == xrng_pkg::OP_RANGED);
    assign quiet_beat = in_beat && (i_s_axis_tuser == xrng_pkg::OP_RESEED ||
                                    i_s_axis_tuser == xrng_pkg::OP_NONE);
    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word   = {o_m_axis_tuser, o_m_axis_tdata};

    // no result beat survives reset
    `ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !o_m_axis_tvalid)

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(out_word))

    // a draw keeps the input closed while it is worked on
    `ASSERT_NEXT(a_draw_busy, i_clk, i_rst_n, draw_beat, !o_s_axis_tready)

    // reseed and unused ops finish in the cycle they arrive
    `ASSERT_NEXT(a_quiet_ready, i_clk, i_rst_n, quiet_beat, o_s_axis_tready && !$rose(o_m_axis_tvalid))

    // the register port never stalls
    `ASSERT_IMPL(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind xoshiro256_starstar_rng_core xrng_port_checks u_xrng_port_checks (.*);

@@ tb/xrng_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xrng_checker
// Watches the input, output and seed-write channels of the xoshiro256**
// core. Keeps its own copy of the seeds and the generator state, and works
// out the draw each accepted input beat should give. Each output beat is
// compared with the oldest expected draw. Hands the mismatch count and the
// number of draws still due to the testbench top.
// ---------------------------------------------------------------------------
module xrng_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] modulus
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [63:0] i_m_axis_tdata,   // [63:0] random_value
    input  logic        i_m_axis_tuser,   // [0] bad_modulus
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_mismatch_count,
    output int          o_pending_count
);

    typedef struct packed {
        logic [63:0] value;
        logic        bad_modulus;
    } t_draw;

    t_draw       draws_due[$];
    logic [63:0] seed_hi;
    logic [63:0] seed_lo;
    logic [63:0] gen_word [4];
    int          mismatches = 0;

    function automatic logic [63:0] rot_up(input logic [63:0] x, input int k);
        logic [127:0] twice;
        twice = {x, x} << k;
        return twice[127:64];
    endfunction

    function automatic logic [63:0] swap_bytes(input logic [63:0] x);
        logic [63:0] r;
        for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = x[56-8*b +: 8];
        end
        return r;
    endfunction

    task automatic reseed_words(input logic [63:0] hi, input logic [63:0] lo);
        logic [63:0] salted;
        salted      = hi + xrng_pkg::SEED_SALT;
        gen_word[0] = salted;
        gen_word[1] = swap_bytes(salted) ^ lo;
        gen_word[2] = swap_bytes(lo) ^ salted;
        gen_word[3] = lo + xrng_pkg::SEED_SALT;
    endtask

    // scrambled output of the current state, then one state step
    function automatic logic [63:0] step_generator();
        logic [63:0] scrambled;
        logic [63:0] shifted;
        scrambled   = rot_up(gen_word[1] * 64'd5, 7) * 64'd9;
        shifted     = gen_word[1] << 17;
        gen_word[2] = gen_word[2] ^ gen_word[0];
        gen_word[3] = gen_word[3] ^ gen_word[1];
        gen_word[1] = gen_word[1] ^ gen_word[2];
        gen_word[0] = gen_word[0] ^ gen_word[3];
        gen_word[2] = gen_word[2] ^ shifted;
        gen_word[3] = rot_up(gen_word[3], 45);
        return scrambled;
    endfunction

    task automatic predict_draw(input xrng_pkg::t_op op, input logic [63:0] modulus);
        logic [63:0] raw;
        case (op)
            xrng_pkg::OP_RESEED: begin
                reseed_words(seed_hi, seed_lo);
            end
            xrng_pkg::OP_RAW: begin
                raw = step_generator();
                draws_due.push_back('{value: raw, bad_modulus: 1'b0});
            end
            xrng_pkg::OP_RANGED: begin
                raw = step_generator();
                if (modulus == 64'd0) begin
                    draws_due.push_back('{value: raw, bad_modulus: 1'b1});
                end else begin
                    draws_due.push_back('{value: raw % modulus, bad_modulus: 1'b0});
                end
            end
            default: begin
                // unused op leaves everything as it is
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_draw want;
        if (!i_rst_n) begin
            seed_hi = '0;
            seed_lo = '0;
            reseed_words('0, '0);
            draws_due.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (draws_due.size() == 0) begin
                    $display("%0t: no draw expected, got random_value %h bad_modulus %b",
                             $time, i_m_axis_tdata, i_m_axis_tuser);
                    mismatches++;
                end else begin
                    want = draws_due.pop_front();
                    if (i_m_axis_tdata !== want.value) begin
                        $display("%0t: random_value expected %h, got %h",
                                 $time, want.value, i_m_axis_tdata);
                        mismatches++;
                    end
                    if (i_m_axis_tuser !== want.bad_modulus) begin
                        $display("%0t: bad_modulus expected %b, got %b",
                                 $time, want.bad_modulus, i_m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_draw(xrng_pkg::t_op'(i_s_axis_tuser), i_s_axis_tdata);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (xrng_pkg::t_cfg_idx'(i_cfg_index))
                    xrng_pkg::CFG_SEED_UPPER: seed_hi = i_cfg_data;
                    xrng_pkg::CFG_SEED_LOWER: seed_lo = i_cfg_data;
                    default:                  ;
                endcase
            end
        end
        o_pending_count  = draws_due.size();
        o_mismatch_count = mismatches;
    end

endmodule

@@ tb/xoshiro256_starstar_rng_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xoshiro256_starstar_rng_core_test
// Drives reseed, raw and ranged draw beats and seed writes into the
// generator core: a directed opening for the corner cases and a long output
// stall, then random beats in four idling and stalling phases. A checker module
// predicts every draw and compares the output stream.
// ---------------------------------------------------------------------------
module xoshiro256_starstar_rng_core_test;

    localparam int RANDOM_ITEMS  = 1120;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 100;
    localparam int STALL_LIMIT   = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = xrng_pkg::OP_RAW;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = xrng_pkg::CFG_SEED_UPPER;
    logic [63:0] i_cfg_data = '0;

    int   mismatch_count;
    int   draws_pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_busy = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    xoshiro256_starstar_rng_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    xrng_checker draw_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .i_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_s_axis_tuser   (i_s_axis_tuser),
        .i_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .i_m_axis_tdata   (o_m_axis_tdata),
        .i_m_axis_tuser   (o_m_axis_tuser),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (draws_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // output side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_busy) begin
            if (hold_left == 0) begin
                hold_busy       <= 1'b0;
                hold_done       <= 1'b1;
                i_m_axis_tready <= 1'b1;
            end else begin
                hold_left       <= hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end
        end else if (hold_req && !hold_done) begin
            hold_busy       <= 1'b1;
            hold_left       <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ends the run when no beat moves on any channel for too long
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input xrng_pkg::t_op op, input logic [63:0] modulus);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= modulus;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // stop offering beats and let every outstanding draw come out
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        wait (draws_pending == 0);
        @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_seeds(input logic [63:0] hi, input logic [63:0] lo);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= xrng_pkg::CFG_SEED_UPPER;
        i_cfg_data  <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= xrng_pkg::CFG_SEED_LOWER;
        i_cfg_data  <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_modulus();
        case ($urandom_range(7))
            0:       return 64'd0;
            1:       return 64'($urandom_range(16, 1));
            2:       return 64'd1 << $urandom_range(63);
            3:       return ~64'd0 - 64'($urandom_range(3));
            4:       return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int            counted;
        int            pick;
        xrng_pkg::t_op op;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // state straight out of reset, zero modulus, modulus extremes
        send_item(xrng_pkg::OP_RAW, 64'd0);
        send_item(xrng_pkg::OP_RANGED, 64'd0);
        send_item(xrng_pkg::OP_RANGED, 64'd1);
        send_item(xrng_pkg::OP_RANGED, ~64'd0);
        send_item(xrng_pkg::OP_RANGED, 64'h8000_0000_0000_0000);
        // unused op must not touch the state
        send_item(xrng_pkg::OP_NONE, ~64'd0);
        send_item(xrng_pkg::OP_RAW, ~64'd0);
        // reseed with the reset seeds brings back the reset state
        send_item(xrng_pkg::OP_RESEED, 64'd0);
        send_item(xrng_pkg::OP_RAW, 64'd0);
        settle();

        program_seeds(~64'd0, ~64'd0);
        send_item(xrng_pkg::OP_RESEED, ~64'd0);
        send_item(xrng_pkg::OP_RAW, 64'd0);
        send_item(xrng_pkg::OP_RANGED, 64'd3);
        send_item(xrng_pkg::OP_RANGED, 64'd2);
        settle();

        // salted words wrap to zero
        program_seeds(64'd0 - xrng_pkg::SEED_SALT, 64'd0 - xrng_pkg::SEED_SALT);
        send_item(xrng_pkg::OP_RESEED, 64'd0);
        send_item(xrng_pkg::OP_RAW, 64'd0);
        send_item(xrng_pkg::OP_RAW, 64'd0);
        send_item(xrng_pkg::OP_RANGED, 64'd7);
        settle();

        // long output hold-off while beats keep coming, so the input stalls
        hold_req <= 1'b1;
        repeat (6) send_item(xrng_pkg::OP_RAW, {$urandom, $urandom});
        send_item(xrng_pkg::OP_RANGED, {$urandom, $urandom});
        wait (hold_done);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (phase == 0) begin
                program_seeds(64'd0, 64'd0);
            end else begin
                program_seeds({$urandom, $urandom}, {$urandom, $urandom});
            end
            counted = 0;
            while (counted < RANDOM_ITEMS / 4) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    op = xrng_pkg::OP_RESEED;
                end else if (pick < 9) begin
                    op = xrng_pkg::OP_NONE;
                end else if (pick < 45) begin
                    op = xrng_pkg::OP_RAW;
                end else begin
                    op = xrng_pkg::OP_RANGED;
                end
                send_item(op, pick_modulus());
                if (op != xrng_pkg::OP_NONE) begin
                    counted++;
                end
                // fresh seeds now and then, only while the core is idle
                if (counted % 90 == 89 && op != xrng_pkg::OP_NONE) begin
                    settle();
                    program_seeds({$urandom, $urandom}, {$urandom, $urandom});
                end
            end
            settle();
        end

        wait (draws_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && draws_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
